### sv/tok_pkg.sv
// Shared types, token kind codes and defaults for the token scanner.
package tok_pkg;

    localparam int CHAR_BITS = 8;
    localparam int KIND_BITS = 5;
    localparam int LEN_BITS  = 16;

    localparam int POSITION_BITS_DEF = 16;
    localparam int FIFO_DEPTH_DEF    = 4;

    typedef logic [KIND_BITS-1:0] tok_kind_t;

    localparam tok_kind_t K_END     = 5'd0;
    localparam tok_kind_t K_ERROR   = 5'd1;
    localparam tok_kind_t K_DOT     = 5'd2;
    localparam tok_kind_t K_COMMA   = 5'd3;
    localparam tok_kind_t K_SEMI    = 5'd4;
    localparam tok_kind_t K_MINUS   = 5'd5;
    localparam tok_kind_t K_PLUS    = 5'd6;
    localparam tok_kind_t K_STAR    = 5'd7;
    localparam tok_kind_t K_SLASH   = 5'd8;
    localparam tok_kind_t K_LBRACE  = 5'd9;
    localparam tok_kind_t K_RBRACE  = 5'd10;
    localparam tok_kind_t K_LPAREN  = 5'd11;
    localparam tok_kind_t K_RPAREN  = 5'd12;
    localparam tok_kind_t K_BANG    = 5'd13;
    localparam tok_kind_t K_EQUAL   = 5'd15;
    localparam tok_kind_t K_LESS    = 5'd17;
    localparam tok_kind_t K_GREATER = 5'd19;
    localparam tok_kind_t K_AND     = 5'd21;
    localparam tok_kind_t K_OR      = 5'd22;
    localparam tok_kind_t K_STRING  = 5'd23;
    localparam tok_kind_t K_NUMBER  = 5'd24;
    localparam tok_kind_t K_IDENT   = 5'd25;

    // Character class of one source byte, decided in the front end.
    typedef struct packed {
        logic      is_zero;
        logic      is_space;
        logic      is_quote;
        logic      is_digit;
        logic      is_word;     // letter, digit or underscore
        logic      is_start;    // letter or underscore
        logic      is_eq;
        logic      is_amp;
        logic      is_bar;
        tok_kind_t single_kind; // zero when not a one-char token
        tok_kind_t pend_kind;   // zero when not a maybe-two-char operator
    } tok_class_t;

    // One classified byte queued for the back end.
    typedef struct packed {
        tok_class_t          cls;
        logic [LEN_BITS-1:0] pos;
    } tok_entry_t;

    typedef struct packed {
        tok_kind_t           kind;
        logic [LEN_BITS-1:0] start;
        logic [LEN_BITS-1:0] length;
    } tok_t;

    // Queue status seen by the front end, the back end and the top level.
    typedef struct packed {
        logic full;
        logic empty;
    } tok_fifo_stat_t;

endpackage

### sv/tok_ifs.sv
// Valid/ready channels for source bytes and tokens.
interface tok_char_if import tok_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface tok_token_if import tok_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [KIND_BITS-1:0] token_kind;
    logic [LEN_BITS-1:0]  token_start;
    logic [LEN_BITS-1:0]  token_length;
    logic                 last_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input last_of_run, output ready);
endinterface

### sv/tok_front.sv
// Front end: accepts source bytes, classifies them and tracks the byte offset.
module tok_front import tok_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    tok_char_if.sink       chars,
    input  tok_fifo_stat_t fifo_stat,
    output logic           push,
    output tok_entry_t     push_entry
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;

    function automatic tok_class_t classify(input logic [CHAR_BITS-1:0] c);
        tok_class_t r;
        logic       digit;
        logic       alpha;
        r           = '0;
        digit       = (c >= "0") && (c <= "9");
        alpha       = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
        r.is_zero   = (c == 8'h00);
        r.is_space  = (c == " ") || ((c >= 8'h09) && (c <= 8'h0D));
        r.is_quote  = (c == "\"");
        r.is_digit  = digit;
        r.is_start  = alpha || (c == "_");
        r.is_word   = alpha || digit || (c == "_");
        r.is_eq     = (c == "=");
        r.is_amp    = (c == "&");
        r.is_bar    = (c == "|");
        unique case (c)
            ".":     r.single_kind = K_DOT;
            ",":     r.single_kind = K_COMMA;
            ";":     r.single_kind = K_SEMI;
            "-":     r.single_kind = K_MINUS;
            "+":     r.single_kind = K_PLUS;
            "*":     r.single_kind = K_STAR;
            "/":     r.single_kind = K_SLASH;
            "{":     r.single_kind = K_LBRACE;
            "}":     r.single_kind = K_RBRACE;
            "(":     r.single_kind = K_LPAREN;
            ")":     r.single_kind = K_RPAREN;
            default: r.single_kind = K_END;
        endcase
        unique case (c)
            "!":     r.pend_kind = K_BANG;
            "=":     r.pend_kind = K_EQUAL;
            "<":     r.pend_kind = K_LESS;
            ">":     r.pend_kind = K_GREATER;
            "&":     r.pend_kind = K_AND;
            "|":     r.pend_kind = K_OR;
            default: r.pend_kind = K_END;
        endcase
        return r;
    endfunction

    assign chars.ready = !fifo_stat.full;
    assign push        = chars.valid && !fifo_stat.full;

    always_comb
    begin
        push_entry.cls = classify(chars.text_byte);
        push_entry.pos = LEN_BITS'(pos_reg);
    end

    // Zero byte ends the text and restarts the offset; otherwise saturate.
    always_comb
    begin
        pos_next = pos_reg;
        if (push_entry.cls.is_zero)
        begin
            pos_next = '0;
        end
        else if (pos_reg != POS_MAX)
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (push)
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

### sv/tok_fifo.sv
// Short queue of classified bytes between front and back end.
module tok_fifo import tok_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tok_entry_t     push_entry,
    input  logic           pop,
    output tok_entry_t     head,
    output tok_fifo_stat_t stat
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    tok_entry_t          mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### sv/tok_back.sv
// Back end: scan state machine and token output register.
module tok_back import tok_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  tok_entry_t     head,
    input  tok_fifo_stat_t fifo_stat,
    output logic           pop,
    tok_token_if.source    tokens
);

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_PEND   = 3'd1,
        MODE_STRING = 3'd2,
        MODE_NUMBER = 3'd3,
        MODE_IDENT  = 3'd4,
        MODE_HALT   = 3'd5
    } mode_t;

    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    mode_t               mode_reg,  mode_next;
    logic [LEN_BITS-1:0] begin_reg, begin_next;
    logic [LEN_BITS-1:0] count_reg, count_next;
    tok_kind_t           pend_reg,  pend_next;
    logic                phase_reg;
    logic                out_valid_reg;
    tok_t                out_tok_reg;
    logic                out_last_reg;

    tok_class_t          cls;
    logic                head_valid;
    logic                scan_fresh;
    logic                emit_a, emit_b;
    tok_t                tok_a, tok_b;
    logic [1:0]          n_tok;
    logic [LEN_BITS-1:0] cnt_inc;
    logic                slot_free;
    logic                split_first;
    logic                load;

    assign cls        = head.cls;
    assign head_valid = !fifo_stat.empty;
    assign cnt_inc    = (count_reg == LEN_MAX) ? count_reg : count_reg + 1'b1;

    always_comb
    begin
        mode_next  = mode_reg;
        begin_next = begin_reg;
        count_next = count_reg;
        pend_next  = pend_reg;
        emit_a     = 1'b0;
        emit_b     = 1'b0;
        tok_a      = '0;
        tok_b      = '0;
        scan_fresh = 1'b0;

        // Token closed (or continued) by this byte in the current mode.
        unique case (mode_reg)
            MODE_PEND:
            begin
                if (pend_reg == K_AND || pend_reg == K_OR)
                begin
                    emit_a = 1'b1;
                    if ((pend_reg == K_AND) ? cls.is_amp : cls.is_bar)
                    begin
                        tok_a     = '{kind: pend_reg, start: begin_reg, length: LEN_BITS'(2)};
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        // lone & or |: error, and the byte is swallowed
                        tok_a     = '{kind: K_ERROR, start: begin_reg, length: LEN_BITS'(1)};
                        mode_next = MODE_HALT;
                    end
                end
                else if (cls.is_eq)
                begin
                    emit_a    = 1'b1;
                    tok_a     = '{kind: pend_reg + 1'b1, start: begin_reg,
                                  length: LEN_BITS'(2)};
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    emit_a     = 1'b1;
                    tok_a      = '{kind: pend_reg, start: begin_reg, length: LEN_BITS'(1)};
                    mode_next  = MODE_IDLE;
                    scan_fresh = 1'b1;
                end
            end
            MODE_STRING:
            begin
                count_next = cnt_inc;
                if (cls.is_quote)
                begin
                    emit_a    = 1'b1;
                    tok_a     = '{kind: K_STRING, start: begin_reg, length: cnt_inc};
                    mode_next = MODE_IDLE;
                end
                else if (cls.is_zero)
                begin
                    emit_a = 1'b1;
                    tok_a  = '{kind: K_END, start: begin_reg, length: '0};
                end
            end
            MODE_NUMBER:
            begin
                if (cls.is_digit)
                begin
                    count_next = cnt_inc;
                end
                else
                begin
                    emit_a     = 1'b1;
                    tok_a      = '{kind: K_NUMBER, start: begin_reg, length: count_reg};
                    mode_next  = MODE_IDLE;
                    scan_fresh = 1'b1;
                end
            end
            MODE_IDENT:
            begin
                if (cls.is_word)
                begin
                    count_next = cnt_inc;
                end
                else
                begin
                    emit_a     = 1'b1;
                    tok_a      = '{kind: K_IDENT, start: begin_reg, length: count_reg};
                    mode_next  = MODE_IDLE;
                    scan_fresh = 1'b1;
                end
            end
            MODE_HALT:
            begin
                mode_next = MODE_HALT;
            end
            default:
            begin
                mode_next  = MODE_IDLE;
                scan_fresh = 1'b1;
            end
        endcase

        // Byte scanned from idle.
        if (scan_fresh)
        begin
            priority if (cls.is_zero)
            begin
                emit_b = 1'b1;
                tok_b  = '{kind: K_END, start: head.pos, length: '0};
            end
            else if (cls.is_space)
            begin
                emit_b = 1'b0;
            end
            else if (cls.single_kind != K_END)
            begin
                emit_b = 1'b1;
                tok_b  = '{kind: cls.single_kind, start: head.pos, length: LEN_BITS'(1)};
            end
            else if (cls.pend_kind != K_END)
            begin
                mode_next  = MODE_PEND;
                pend_next  = cls.pend_kind;
                begin_next = head.pos;
            end
            else
            begin
                begin_next = head.pos;
                count_next = LEN_BITS'(1);
                priority if (cls.is_quote)
                begin
                    mode_next = MODE_STRING;
                end
                else if (cls.is_digit)
                begin
                    mode_next = MODE_NUMBER;
                end
                else if (cls.is_start)
                begin
                    mode_next = MODE_IDENT;
                end
                else
                begin
                    emit_b    = 1'b1;
                    tok_b     = '{kind: K_ERROR, start: head.pos, length: LEN_BITS'(1)};
                    mode_next = MODE_HALT;
                end
            end
        end

        // End of text restores everything to the reset state.
        if (cls.is_zero)
        begin
            mode_next  = MODE_IDLE;
            begin_next = '0;
            count_next = '0;
            pend_next  = K_END;
        end
    end

    assign n_tok       = {1'b0, emit_a} + {1'b0, emit_b};
    assign slot_free   = !out_valid_reg || tokens.ready;
    assign split_first = (n_tok == 2'd2) && !phase_reg;
    assign load        = head_valid && (n_tok != 2'd0) && slot_free;
    assign pop         = head_valid && ((n_tok == 2'd0) || (slot_free && !split_first));

    assign tokens.valid        = out_valid_reg;
    assign tokens.token_kind   = out_tok_reg.kind;
    assign tokens.token_start  = out_tok_reg.start;
    assign tokens.token_length = out_tok_reg.length;
    assign tokens.last_of_run  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            begin_reg     <= '0;
            count_reg     <= '0;
            pend_reg      <= K_END;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_tok_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                mode_reg  <= mode_next;
                begin_reg <= begin_next;
                count_reg <= count_next;
                pend_reg  <= pend_next;
                phase_reg <= 1'b0;
            end
            else if (load && split_first)
            begin
                phase_reg <= 1'b1;
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= !split_first;
                if (phase_reg)
                begin
                    out_tok_reg <= tok_b;
                end
                else
                begin
                    out_tok_reg <= emit_a ? tok_a : tok_b;
                end
            end
            else if (tokens.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### sv/token_scanner.sv
// Byte-serial lexical scanner. Source text arrives on "chars" one byte per
// request, a zero byte ending the text; tokens leave on "tokens" as kind,
// start offset (low 16 bits), saturating length and a last_of_run flag that
// marks the final token a byte caused. Throughput is one byte per cycle
// while the output does not stall: the front end classifies a byte and
// queues it in the same cycle it is accepted, and the back end's scan
// state machine retires one queued byte per cycle. A byte that both closes
// a pending token and produces one of its own (for instance the '+' in
// "x+") yields two tokens and holds the back end until both are loaded,
// since the single output register takes one token per cycle; the byte
// queue (FIFO_DEPTH entries) absorbs these bursts and output stalls. Words
// are reported as identifiers; keywords are not distinguished. After an
// error token the scanner ignores input until the zero byte, which
// restarts the offset at zero.
module token_scanner import tok_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int FIFO_DEPTH    = FIFO_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tok_char_if.sink    chars,
    tok_token_if.source tokens
);

    logic           push;
    logic           pop;
    tok_entry_t     push_entry;
    tok_entry_t     head;
    tok_fifo_stat_t fifo_stat;

    // classify and stamp offset
    tok_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .fifo_stat  (fifo_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    // decouples front from the scan state machine
    tok_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (fifo_stat)
    );

    // scan state, up to two tokens per byte
    tok_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .fifo_stat (fifo_stat),
        .pop       (pop),
        .tokens    (tokens)
    );

`ifndef NO_ASSERTIONS
    // full queue must back-pressure the byte source
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_stat.full |-> !chars.ready)
        else $error("byte accepted while queue full");

    // a pop always needs a queued byte
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !fifo_stat.empty)
        else $error("pop from empty queue");

    // end tokens carry zero length, error tokens length one
    a_end_len: assert property (@(posedge clk) disable iff (!rst_n)
        tokens.valid && (tokens.token_kind == K_END) |-> (tokens.token_length == '0))
        else $error("end token with nonzero length");

    a_err_len: assert property (@(posedge clk) disable iff (!rst_n)
        tokens.valid && (tokens.token_kind == K_ERROR) |->
            (tokens.token_length == LEN_BITS'(1)) && tokens.last_of_run)
        else $error("malformed error token");
`endif

endmodule

### sim/tb_token_scanner.sv
`timescale 1ns / 1ps
// Self-checking testbench for token_scanner: random and directed source text, token checks.
module tb_token_scanner import tok_pkg::*; ();

    localparam int POS_BITS     = POSITION_BITS_DEF;
    localparam int RANDOM_ITEMS = 1150;
    localparam int HOLD_AT      = 250;     // requests accepted before the long output stall
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 200000;

    localparam bit [7:0] CH_NUL   = 8'h00;
    localparam bit [7:0] CH_QUOTE = 8'h22;
    localparam bit [7:0] CH_EQ    = 8'h3D;
    localparam bit [7:0] CH_AMP   = 8'h26;
    localparam bit [7:0] CH_BAR   = 8'h7C;

    localparam string START_SET = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    localparam string WORD_SET  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    localparam string DIGIT_SET = "0123456789";

    // kind code zero doubles as "no operator" in the character lookup
    localparam tok_kind_t NOT_OP = K_END;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_PEND,     // one-char operator waiting on its second byte
        SCAN_STRING,
        SCAN_NUMBER,
        SCAN_IDENT,
        SCAN_HALT      // after an error, until the zero byte
    } scan_mode_e;

    typedef struct packed {
        tok_kind_t           kind;
        logic [LEN_BITS-1:0] start;
        logic [LEN_BITS-1:0] length;
        logic                last;
    } token_note_t;

    // Scanner state mirror plus the list of tokens still owed by the block.
    class scan_tracker;
        bit [POS_BITS-1:0] position;
        scan_mode_e        mode;
        bit [LEN_BITS-1:0] tok_begin;
        bit [LEN_BITS-1:0] run_len;
        tok_kind_t         held_op;
        token_note_t       tokens_due[$];
        token_note_t       step_q[$];
        int                errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            position  = '0;
            mode      = SCAN_IDLE;
            tok_begin = '0;
            run_len   = '0;
            held_op   = K_END;
        endfunction

        function bit digit_char(bit [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit alpha_char(bit [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function void emit(tok_kind_t kind, bit [LEN_BITS-1:0] start,
                           bit [LEN_BITS-1:0] length);
            token_note_t t;
            if (step_q.size() < 2)
            begin
                t.kind   = kind;
                t.start  = start;
                t.length = length;
                t.last   = 1'b0;
                step_q.push_back(t);
            end
        endfunction

        // Advance by one accepted byte; returns 0 when the byte was ignored (halted).
        function bit take_byte(bit [7:0] c);
            bit [POS_BITS-1:0] here;
            bit                settled;
            bit                restart;
            bit                live;
            tok_kind_t         k_one;
            tok_kind_t         k_two;
            here    = position;
            settled = 1'b0;
            restart = 1'b0;
            live    = (mode != SCAN_HALT);
            step_q.delete();

            case (mode)
                SCAN_PEND:
                begin
                    if (held_op == K_AND || held_op == K_OR)
                    begin
                        if (c == ((held_op == K_AND) ? CH_AMP : CH_BAR))
                        begin
                            emit(held_op, tok_begin, 16'd2);
                            mode = SCAN_IDLE;
                        end
                        else
                        begin
                            // lone & or |: error at the operator, this byte is swallowed
                            emit(K_ERROR, tok_begin, 16'd1);
                            mode    = SCAN_HALT;
                            restart = (c == CH_NUL);
                        end
                        settled = 1'b1;
                    end
                    else if (c == CH_EQ)
                    begin
                        emit(tok_kind_t'(held_op + 1), tok_begin, 16'd2);
                        mode    = SCAN_IDLE;
                        settled = 1'b1;
                    end
                    else
                    begin
                        emit(held_op, tok_begin, 16'd1);
                        mode = SCAN_IDLE;
                    end
                end
                SCAN_STRING:
                begin
                    if (run_len != '1)
                        run_len++;
                    if (c == CH_QUOTE)
                    begin
                        emit(K_STRING, tok_begin, run_len);
                        mode = SCAN_IDLE;
                    end
                    else if (c == CH_NUL)
                    begin
                        // unterminated: end token points at the opening quote
                        emit(K_END, tok_begin, 16'd0);
                        restart = 1'b1;
                    end
                    settled = 1'b1;
                end
                SCAN_NUMBER:
                begin
                    if (digit_char(c))
                    begin
                        if (run_len != '1)
                            run_len++;
                        settled = 1'b1;
                    end
                    else
                    begin
                        emit(K_NUMBER, tok_begin, run_len);
                        mode = SCAN_IDLE;
                    end
                end
                SCAN_IDENT:
                begin
                    if (alpha_char(c) || digit_char(c) || c == "_")
                    begin
                        if (run_len != '1)
                            run_len++;
                        settled = 1'b1;
                    end
                    else
                    begin
                        emit(K_IDENT, tok_begin, run_len);
                        mode = SCAN_IDLE;
                    end
                end
                SCAN_HALT:
                begin
                    restart = (c == CH_NUL);
                    settled = 1'b1;
                end
                default:
                    mode = SCAN_IDLE;
            endcase

            // byte not consumed above: scan it from idle
            if (!settled)
            begin
                k_one = NOT_OP;
                k_two = NOT_OP;
                case (c)
                    ".": k_one = K_DOT;
                    ",": k_one = K_COMMA;
                    ";": k_one = K_SEMI;
                    "-": k_one = K_MINUS;
                    "+": k_one = K_PLUS;
                    "*": k_one = K_STAR;
                    "/": k_one = K_SLASH;
                    "{": k_one = K_LBRACE;
                    "}": k_one = K_RBRACE;
                    "(": k_one = K_LPAREN;
                    ")": k_one = K_RPAREN;
                    "!": k_two = K_BANG;
                    "=": k_two = K_EQUAL;
                    "<": k_two = K_LESS;
                    ">": k_two = K_GREATER;
                    "&": k_two = K_AND;
                    "|": k_two = K_OR;
                    default: k_one = NOT_OP;
                endcase
                if (c == CH_NUL)
                begin
                    emit(K_END, here[LEN_BITS-1:0], 16'd0);
                    restart = 1'b1;
                end
                else if (!(c == " " || (c >= 8'd9 && c <= 8'd13)))
                begin
                    if (k_one != NOT_OP)
                        emit(k_one, here[LEN_BITS-1:0], 16'd1);
                    else if (k_two != NOT_OP)
                    begin
                        mode      = SCAN_PEND;
                        held_op   = k_two;
                        tok_begin = here[LEN_BITS-1:0];
                    end
                    else
                    begin
                        tok_begin = here[LEN_BITS-1:0];
                        run_len   = 16'd1;
                        if (c == CH_QUOTE)
                            mode = SCAN_STRING;
                        else if (digit_char(c))
                            mode = SCAN_NUMBER;
                        else if (alpha_char(c) || c == "_")
                            mode = SCAN_IDENT;
                        else
                        begin
                            emit(K_ERROR, here[LEN_BITS-1:0], 16'd1);
                            mode = SCAN_HALT;
                        end
                    end
                end
            end

            if (step_q.size() > 0)
                step_q[step_q.size()-1].last = 1'b1;
            foreach (step_q[i])
                tokens_due.push_back(step_q[i]);

            if (restart)
                clear();
            else if (position != '1)
                position++;
            return live;
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("[%0t] token mismatch: %s", $time, what);
        endtask

        task match_token(tok_kind_t kind, logic [LEN_BITS-1:0] start,
                         logic [LEN_BITS-1:0] length, logic last);
            token_note_t want;
            if (tokens_due.size() == 0)
                report_mismatch($sformatf("unexpected token kind %0d start %0d length %0d",
                                          kind, start, length));
            else
            begin
                want = tokens_due.pop_front();
                if (kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d (start %0d)",
                                              kind, want.kind, want.start));
                if (start !== want.start)
                    report_mismatch($sformatf("start %0d, want %0d (kind %0d)",
                                              start, want.start, want.kind));
                if (length !== want.length)
                    report_mismatch($sformatf("length %0d, want %0d (kind %0d start %0d)",
                                              length, want.length, want.kind, want.start));
                if (last !== want.last)
                    report_mismatch($sformatf("last_of_run %b, want %b (kind %0d start %0d)",
                                              last, want.last, want.kind, want.start));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          scanned_items;
    int          cycle_count = 0;
    bit [7:0]    text_q[$];
    scan_tracker book = new();

    tok_char_if  chars ();
    tok_token_if tokens ();

    token_scanner dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .tokens (tokens)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the handshakes hang.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_token_scanner: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Text generation. A text is a run of lexemes closed by a zero byte;
    // lexemes are packed with no separator at random so that lookahead
    // cases (token closed by the next token's first byte) happen often.
    // ---------------------------------------------------------------------
    function automatic bit [7:0] pick(string set);
        return set[$urandom_range(set.len() - 1)];
    endfunction

    // any nonzero byte but the closing quote, high half included
    function automatic bit [7:0] string_byte();
        bit [7:0] b;
        b = 8'($urandom_range(1, 255));
        return (b == CH_QUOTE) ? 8'h27 : b;
    endfunction

    function automatic void add_lexeme();
        int       n;
        bit [7:0] b;
        case ($urandom_range(9))
            0, 1:
            begin
                text_q.push_back(pick(START_SET));
                n = $urandom_range(6);
                repeat (n) text_q.push_back(pick(WORD_SET));
            end
            2:
            begin
                n = $urandom_range(1, 5);
                repeat (n) text_q.push_back(pick(DIGIT_SET));
            end
            3:
            begin
                text_q.push_back(CH_QUOTE);
                n = $urandom_range(6);
                repeat (n) text_q.push_back(string_byte());
                text_q.push_back(CH_QUOTE);
            end
            4, 5:
                text_q.push_back(pick(".,;-+*/{}()"));
            6:
            begin
                text_q.push_back(pick("!=<>"));
                if ($urandom_range(1))
                    text_q.push_back(CH_EQ);
            end
            7:
            begin
                b = pick("&|");
                text_q.push_back(b);
                text_q.push_back(b);
            end
            default:
            begin
                // whitespace: space or one of the control codes 9..13
                n = $urandom_range(9, 14);
                text_q.push_back(n == 14 ? 8'h20 : 8'(n));
            end
        endcase
    endfunction

    // Mostly well-formed text; some carry one flaw near the end so that
    // little of the text is lost to the halted state.
    function automatic void build_text();
        int n;
        text_q.delete();
        n = $urandom_range(12);
        repeat (n) add_lexeme();
        if ($urandom_range(99) < 15)
        begin
            case ($urandom_range(3))
                0: text_q.push_back(8'($urandom_range(1, 255)));
                1: text_q.push_back($urandom_range(1) ? pick("#$@~^?:[]%")
                                                      : 8'($urandom_range(128, 255)));
                2: text_q.push_back(pick("&|"));
                default:
                begin
                    // string cut short by the end of text
                    text_q.push_back(CH_QUOTE);
                    n = $urandom_range(4);
                    repeat (n) text_q.push_back(string_byte());
                    text_q.push_back(CH_NUL);
                    return;
                end
            endcase
            n = $urandom_range(2);
            repeat (n) add_lexeme();
        end
        text_q.push_back(CH_NUL);
    endfunction

    // ---------------------------------------------------------------------
    // Byte sender. Valid stays high across back-to-back requests; a gap
    // drops it before the next byte is offered.
    // ---------------------------------------------------------------------
    task automatic send_byte(input bit [7:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            chars.valid <= 1'b0;
            @(posedge clk);
        end
        chars.valid     <= 1'b1;
        chars.text_byte <= c;
        do
            @(posedge clk);
        while (chars.ready !== 1'b1);
        if (book.take_byte(c))
            scanned_items++;
    endtask

    task automatic send_source(input string s);
        foreach (s[i])
            send_byte(s[i]);
        send_byte(CH_NUL);
    endtask

    // ---------------------------------------------------------------------
    // Token receiver. Checks each accepted token against the oldest one owed,
    // then picks ready for the next cycle. Once, after HOLD_AT requests have
    // gone in, ready is held low for HOLD_CYCLES so the byte queue fills and
    // the block has to push back on the sender.
    // ---------------------------------------------------------------------
    initial
    begin : token_sink
        int accepted_reqs;
        bit held;
        accepted_reqs = 0;
        held          = 1'b0;
        tokens.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (chars.valid === 1'b1 && chars.ready === 1'b1)
                accepted_reqs++;
            if (tokens.valid === 1'b1 && tokens.ready === 1'b1)
                book.match_token(tokens.token_kind, tokens.token_start,
                                 tokens.token_length, tokens.last_of_run);
            if (!held && accepted_reqs >= HOLD_AT)
            begin
                held = 1'b1;
                tokens.ready <= 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    @(posedge clk);
                    if (chars.valid === 1'b1 && chars.ready === 1'b1)
                        accepted_reqs++;
                end
            end
            else
                tokens.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence: reset, directed texts, random texts in three idle
    // phases, then drain and verdict.
    // ---------------------------------------------------------------------
    initial
    begin : stimulus
        rst_n           <= 1'b0;
        chars.valid     <= 1'b0;
        chars.text_byte <= '0;
        send_idle_pct = 19;
        recv_idle_pct = 83;
        scanned_items = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // every one-char token, every lone and paired operator, then end of text
        send_source(".,;-+*/{}()=!<>!===<=>=&&||");
        // identifier with underscore and digit, number, string holding byte 255
        send_source("_a9 12\"x\377\"");
        // lone '&' swallows the next byte and halts until the zero byte
        send_source("&a");
        // lone '|' right before the zero byte ends the text itself
        send_source("|");
        // unterminated string
        send_source("\"ab");
        // byte 255 is illegal: error, then the digit is ignored
        send_source("\3771");

        scanned_items = 0;
        while (scanned_items < RANDOM_ITEMS)
        begin
            if (scanned_items >= 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (scanned_items >= RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 83;
                recv_idle_pct = 19;
            end
            build_text();
            foreach (text_q[i])
                send_byte(text_q[i]);
        end

        chars.valid <= 1'b0;
        while (book.tokens_due.size() != 0)
            @(posedge clk);
        // catch any stray token that trails the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (book.errors == 0)
            $display("tb_token_scanner: done, clean");
        else
            $display("tb_token_scanner: done, errors");
        $finish;
    end

endmodule

### token_scanner.f
sv/tok_pkg.sv
sv/tok_ifs.sv
sv/tok_front.sv
sv/tok_fifo.sv
sv/tok_back.sv
sv/token_scanner.sv
sim/tb_token_scanner.sv
